FILE: rtl/phist_pkg.sv
// Shared types and constants for the pixel histogram cell chain.
package phist_pkg;

  localparam int unsigned OUT_W = 32;
  localparam int unsigned FIELD_W = 8;

  typedef enum logic [1:0] {
    OP_ACCUM = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef struct packed {
    logic valid;
    op_e  op;
  } ctl_t;

endpackage

FILE: rtl/pixel_histogram_256_top.sv
// Top level of the pixel histogram: input decode, bin cell chain and output register.
//
// Usage: items enter on in_valid_i / in_stall_o with op_i, pixel_value_i and
// bin_index_i. An accumulate adds one to the bin of pixel_value_i (saturating),
// a read returns the bin of bin_index_i on out_valid_o / out_stall_i as
// bin_count_o, a clear zeroes all bins. Op code 3 is dropped.
// Each bin lives in one cell of a chain of 2**VALUE_BITS cells; an item moves
// one cell per cycle while the chain advances, acting on the cell whose bin it
// names (a clear zeroes every cell), so items stay in order at every bin.
// Throughput: one item per cycle while the output is not stalled.
// A read result passes through the register of every cell in the chain and then
// the output register; output stalls hold it longer.
// Reset clears every bin and empties the chain and the output register at once.
// While a result waits with out_stall_i high, the whole chain holds and
// in_stall_o is high; no item is accepted until the result is taken.
module pixel_histogram_256_top #(
  parameter int unsigned VALUE_BITS  = 8,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        op_i,
  input  logic [phist_pkg::FIELD_W-1:0]     pixel_value_i,
  input  logic [phist_pkg::FIELD_W-1:0]     bin_index_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [phist_pkg::OUT_W-1:0]       bin_count_o
);

  localparam int unsigned DEPTH = 1 << VALUE_BITS;

  phist_pkg::ctl_t              ctl   [DEPTH+1];
  logic [VALUE_BITS-1:0]        key   [DEPTH+1];
  logic [phist_pkg::OUT_W-1:0]  data  [DEPTH+1];
  logic [phist_pkg::FIELD_W-1:0] sel_field;
  logic                         adv;
  logic                         op_ok;
  logic                         out_valid_q;
  logic                         out_valid_d;
  logic [phist_pkg::OUT_W-1:0]  bin_count_q;

  assign adv = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  assign op_ok = (op_i == phist_pkg::OP_ACCUM) || (op_i == phist_pkg::OP_READ) ||
                 (op_i == phist_pkg::OP_CLEAR);
  assign sel_field = (op_i == phist_pkg::OP_READ) ? bin_index_i : pixel_value_i;

  assign ctl[0].valid = in_valid_i && op_ok;
  assign ctl[0].op    = phist_pkg::op_e'(op_i);
  assign data[0]      = '0;

  generate
    if (VALUE_BITS >= phist_pkg::FIELD_W) begin : g_key_ext
      assign key[0] = VALUE_BITS'(sel_field);
    end else begin : g_key_cut
      assign key[0] = sel_field[VALUE_BITS-1:0];
    end
  endgenerate

  generate
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      phist_cell #(
        .VALUE_BITS  (VALUE_BITS),
        .COUNT_WIDTH (COUNT_WIDTH),
        .CELL_ID     (i)
      ) u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .adv_i  (adv),
        .ctl_i  (ctl[i]),
        .key_i  (key[i]),
        .data_i (data[i]),
        .ctl_o  (ctl[i+1]),
        .key_o  (key[i+1]),
        .data_o (data[i+1])
      );
    end
  endgenerate

  assign out_valid_d = ctl[DEPTH].valid && (ctl[DEPTH].op == phist_pkg::OP_READ);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      bin_count_q <= data[DEPTH];
    end
  end

  assign out_valid_o = out_valid_q;
  assign bin_count_o = bin_count_q;

  a_rise_from_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(out_valid_d))
    else $error("result raised without a read item at the chain end");

  a_hold_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(bin_count_o)))
    else $error("pending result lost while stalled");

  a_chain_frozen : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(ctl[DEPTH]))
    else $error("chain advanced while output stalled");

endmodule

FILE: rtl/phist_cell.sv
// One histogram bin: holds its count and passes the item stream to the next cell.
module phist_cell #(
  parameter int unsigned VALUE_BITS  = 8,
  parameter int unsigned COUNT_WIDTH = 32,
  parameter int unsigned CELL_ID     = 0
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         adv_i,
  input  phist_pkg::ctl_t              ctl_i,
  input  logic [VALUE_BITS-1:0]        key_i,
  input  logic [phist_pkg::OUT_W-1:0]  data_i,
  output phist_pkg::ctl_t              ctl_o,
  output logic [VALUE_BITS-1:0]        key_o,
  output logic [phist_pkg::OUT_W-1:0]  data_o
);

  localparam logic [VALUE_BITS-1:0]  MY_KEY    = VALUE_BITS'(CELL_ID);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  phist_pkg::ctl_t               ctl_q;
  logic [VALUE_BITS-1:0]         key_q;
  logic [phist_pkg::OUT_W-1:0]   data_q;
  logic [phist_pkg::OUT_W-1:0]   data_d;
  logic [COUNT_WIDTH-1:0]        count_q;
  logic [COUNT_WIDTH-1:0]        count_d;
  logic [phist_pkg::OUT_W-1:0]   count_sat;
  logic                          hit;

  generate
    if (COUNT_WIDTH > phist_pkg::OUT_W) begin : g_sat
      assign count_sat = (|count_q[COUNT_WIDTH-1:phist_pkg::OUT_W]) ?
                         '1 : count_q[phist_pkg::OUT_W-1:0];
    end else begin : g_ext
      assign count_sat = phist_pkg::OUT_W'(count_q);
    end
  endgenerate

  assign hit = (key_i == MY_KEY);

  always_comb begin
    count_d = count_q;
    data_d  = data_i;
    if (adv_i && ctl_i.valid) begin
      unique case (ctl_i.op)
        phist_pkg::OP_ACCUM: begin
          if (hit && (count_q != COUNT_MAX)) begin
            count_d = count_q + COUNT_WIDTH'(1);
          end
        end
        phist_pkg::OP_READ: begin
          if (hit) begin
            data_d = count_sat;
          end
        end
        phist_pkg::OP_CLEAR: begin
          count_d = '0;
        end
        default: begin
          count_d = count_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q   <= '0;
      count_q <= '0;
    end else begin
      count_q <= count_d;
      if (adv_i) begin
        ctl_q <= ctl_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      key_q  <= key_i;
      data_q <= data_d;
    end
  end

  assign ctl_o  = ctl_q;
  assign key_o  = key_q;
  assign data_o = data_q;

endmodule

FILE: verif/phist_checker.sv
`timescale 1ns / 1ps
// Checker for the pixel histogram: tracks bin counts and compares every read result.
module phist_checker #(
  parameter int unsigned VALUE_BITS  = 8,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [1:0]                    op_i,
  input  logic [phist_pkg::FIELD_W-1:0] pixel_value_i,
  input  logic [phist_pkg::FIELD_W-1:0] bin_index_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [phist_pkg::OUT_W-1:0]   bin_count_i,
  output int                            fail_count_o,
  output int                            pending_o
);

  localparam int unsigned FIELD_W = phist_pkg::FIELD_W;
  localparam int unsigned OUT_W   = phist_pkg::OUT_W;
  localparam int unsigned BINS = 1 << VALUE_BITS;
  localparam logic [COUNT_WIDTH-1:0] COUNT_FULL = '1;
  localparam logic [63:0] OUT_FULL = 64'hFFFF_FFFF;

  typedef struct packed {
    logic [FIELD_W-1:0] bin;
    logic [OUT_W-1:0]   count;
  } bin_read_t;

  logic [COUNT_WIDTH-1:0] bin_tally [BINS];
  bin_read_t awaited_reads [$];
  bin_read_t want;
  int fails = 0;
  int awaited = 0;

  assign fail_count_o = fails;
  assign pending_o    = awaited;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    fails++;
  endtask

  function automatic logic [OUT_W-1:0] clip_count(input logic [COUNT_WIDTH-1:0] c);
    logic [63:0] wide;
    wide = 64'(c);
    return (wide > OUT_FULL) ? '1 : wide[OUT_W-1:0];
  endfunction

  task automatic apply_item(input logic [1:0] code, input logic [FIELD_W-1:0] pix,
                            input logic [FIELD_W-1:0] bin);
    int unsigned p;
    int unsigned b;
    bin_read_t rd;
    p = pix % BINS;
    b = bin % BINS;
    case (code)
      phist_pkg::OP_ACCUM: begin
        if (bin_tally[p] != COUNT_FULL) bin_tally[p] = bin_tally[p] + 1'b1;
      end
      phist_pkg::OP_READ: begin
        rd.bin   = bin;
        rd.count = clip_count(bin_tally[b]);
        awaited_reads.push_back(rd);
      end
      phist_pkg::OP_CLEAR: begin
        foreach (bin_tally[i]) bin_tally[i] = '0;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (bin_tally[i]) bin_tally[i] = '0;
      awaited_reads.delete();
    end else begin
      if ($isunknown({out_valid_i, in_stall_i})) begin
        report_mismatch("unknown value on out_valid_o or in_stall_o");
      end
      if (out_valid_i && !out_stall_i) begin
        if (awaited_reads.size() == 0) begin
          report_mismatch($sformatf("count %0d with no read outstanding", bin_count_i));
        end else begin
          want = awaited_reads.pop_front();
          if (bin_count_i !== want.count) begin
            report_mismatch($sformatf("bin %0d count %0d, expected %0d",
                                      want.bin, bin_count_i, want.count));
          end
        end
      end
      if (in_valid_i && !in_stall_i) apply_item(op_i, pixel_value_i, bin_index_i);
    end
    awaited = awaited_reads.size();
  end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the pixel histogram: drives items and result stalls, gives the verdict.
module tb_top;

  localparam int unsigned FIELD_W = phist_pkg::FIELD_W;
  localparam int unsigned OUT_W   = phist_pkg::OUT_W;
  localparam int unsigned VALUE_BITS  = 8;
  localparam int unsigned COUNT_WIDTH = 32;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int PHASES = 5;
  localparam int DRAIN_CYCLES = (1 << VALUE_BITS) + 64;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           op = phist_pkg::OP_ACCUM;
  logic [FIELD_W-1:0]   pixel_value = '0;
  logic [FIELD_W-1:0]   bin_index = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [OUT_W-1:0]     bin_count;
  int                   fail_count;
  int                   pending_reads;
  logic [FIELD_W-1:0]   hot_pix [4];

  pixel_histogram_256_top #(
    .VALUE_BITS (VALUE_BITS),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .op_i         (op),
    .pixel_value_i(pixel_value),
    .bin_index_i  (bin_index),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .bin_count_o  (bin_count)
  );

  phist_checker #(
    .VALUE_BITS (VALUE_BITS),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .op_i         (op),
    .pixel_value_i(pixel_value),
    .bin_index_i  (bin_index),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .bin_count_i  (bin_count),
    .fail_count_o (fail_count),
    .pending_o    (pending_reads)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [FIELD_W-1:0] pick_pixel();
    if ($urandom_range(0, 9) < 7) return hot_pix[$urandom_range(0, 3)];
    return FIELD_W'($urandom_range(0, 255));
  endfunction

  // hold the item until accepted
  task automatic send_op(input logic [1:0] code, input logic [FIELD_W-1:0] pix,
                         input logic [FIELD_W-1:0] bin);
    in_valid    <= 1'b1;
    op          <= code;
    pixel_value <= pix;
    bin_index   <= bin;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic idle_gap(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_reads != 0);
  endtask

  // result side: short stalls, a few long ones, and long stall-free stretches
  initial begin
    forever begin
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(100, 300)) @(posedge clk);
      else repeat ($urandom_range(1, 8)) @(posedge clk);
      out_stall <= 1'b1;
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(10, 40)) @(posedge clk);
      else repeat ($urandom_range(1, 3)) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  initial begin
    int  sent;
    int  r;
    bit  gaps_on;
    do @(posedge clk); while (!rst_n);

    send_op(phist_pkg::OP_READ, 8'h00, 8'h00);
    send_op(phist_pkg::OP_READ, 8'hFF, 8'hFF);
    send_op(phist_pkg::OP_ACCUM, 8'h00, 8'hFF);
    send_op(phist_pkg::OP_ACCUM, 8'hFF, 8'h00);
    send_op(phist_pkg::OP_ACCUM, 8'hFF, 8'h00);
    send_op(phist_pkg::OP_ACCUM, 8'hAA, 8'h55);
    send_op(phist_pkg::OP_ACCUM, 8'h55, 8'hAA);
    send_op(phist_pkg::OP_READ, 8'hFF, 8'h00);
    send_op(phist_pkg::OP_READ, 8'h00, 8'hFF);
    send_op(phist_pkg::OP_READ, 8'h55, 8'hAA);
    send_op(phist_pkg::OP_READ, 8'hAA, 8'h55);
    send_op(OP_UNUSED, 8'h0F, 8'hF0);
    send_op(phist_pkg::OP_READ, 8'hF0, 8'h0F);
    send_op(phist_pkg::OP_READ, 8'h0F, 8'hF0);
    send_op(phist_pkg::OP_ACCUM, 8'h0F, 8'h0F);
    send_op(phist_pkg::OP_READ, 8'h0F, 8'h0F);
    drain_results();
    send_op(phist_pkg::OP_CLEAR, 8'hFF, 8'hFF);
    send_op(phist_pkg::OP_READ, 8'h00, 8'hFF);
    send_op(phist_pkg::OP_ACCUM, 8'hFF, 8'hFF);
    send_op(phist_pkg::OP_READ, 8'h00, 8'hFF);
    send_op(phist_pkg::OP_ACCUM, 8'h0F, 8'h00);
    send_op(phist_pkg::OP_CLEAR, 8'h00, 8'h00);
    send_op(phist_pkg::OP_READ, 8'h00, 8'h0F);
    drain_results();

    for (int phase = 0; phase < PHASES; phase++) begin
      gaps_on = (phase != 2);
      foreach (hot_pix[i]) hot_pix[i] = FIELD_W'($urandom_range(0, 255));
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          send_op(phist_pkg::OP_ACCUM, pick_pixel(), FIELD_W'($urandom_range(0, 255)));
          sent++;
        end else if (r < 92) begin
          send_op(phist_pkg::OP_READ, FIELD_W'($urandom_range(0, 255)), pick_pixel());
          sent++;
        end else if (r < 94) begin
          send_op(phist_pkg::OP_CLEAR, FIELD_W'($urandom_range(0, 255)),
                  FIELD_W'($urandom_range(0, 255)));
          sent++;
        end else begin
          send_op(OP_UNUSED, pick_pixel(), pick_pixel());
        end
        if ($urandom_range(0, 59) == 0) drain_results();
        else if (gaps_on) idle_gap(pick_gap());
      end
      if ($urandom_range(0, 1) == 0) drain_results();
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/phist_pkg.sv
rtl/phist_cell.sv
rtl/pixel_histogram_256_top.sv
verif/phist_checker.sv
verif/tb_top.sv
